/* design/mpt_pkg.sv */
// Shared types and constants for the multimode timer.
`default_nettype none

package mpt_pkg;

    // Timer mode codes; codes above the last one run as pulse.
    typedef enum logic [2:0] {
        MODE_PULSE       = 3'd0,
        MODE_ON_DELAY    = 3'd1,
        MODE_OFF_DELAY   = 3'd2,
        MODE_INTERVAL    = 3'd3,
        MODE_INTERVAL_EN = 3'd4
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TIMER_MODE     = 2'd0,
        CFG_DURATION_MS    = 2'd1,
        CFG_PERIOD_MS      = 2'd2,
        CFG_START_ON_PHASE = 2'd3
    } cfg_index_t;

    // Phase codes reported with every result item.
    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_ON   = 2'd1,
        PHASE_OFF  = 2'd2
    } phase_t;

    localparam int unsigned TIME_W = 32;

    typedef logic [TIME_W-1:0] time_ms_t;

    // Configuration as seen by the timer core.
    typedef struct packed {
        logic [2:0] timer_mode;
        time_ms_t   duration_ms;
        time_ms_t   period_ms;
        logic       start_on_phase;
    } cfg_t;

    // One input item.
    typedef struct packed {
        logic     trigger;
        logic     enable;
        time_ms_t now_ms;
    } sample_t;

    // One result item.
    typedef struct packed {
        logic     output_on;
        logic     running;
        phase_t   phase_code;
        time_ms_t remaining_ms;
        time_ms_t phase_remaining_ms;
    } result_t;

    // Timer channel state carried from item to item.
    typedef struct packed {
        logic     last_trigger;
        logic     output_latch;
        logic     cycle_started;
        logic     in_on_phase;
        time_ms_t phase_start_ms;
    } timer_state_t;

endpackage

`default_nettype wire

/* design/mpt_cfg_regs.sv */
// Configuration register file for the multimode timer.
`default_nettype none

module mpt_cfg_regs (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_wdata,
    output mpt_pkg::cfg_t             cfg
);

    mpt_pkg::cfg_t cfg_reg;
    mpt_pkg::cfg_t cfg_next;

    // Decode the write index and update the addressed register.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                mpt_pkg::CFG_TIMER_MODE:     cfg_next.timer_mode     = cfg_wdata[2:0];
                mpt_pkg::CFG_DURATION_MS:    cfg_next.duration_ms    = cfg_wdata;
                mpt_pkg::CFG_PERIOD_MS:      cfg_next.period_ms      = cfg_wdata;
                mpt_pkg::CFG_START_ON_PHASE: cfg_next.start_on_phase = cfg_wdata[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    // All registers reset to zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* design/mpt_core.sv */
// Timer state registers and the single-pass evaluation of one sample.
`default_nettype none

module mpt_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire mpt_pkg::cfg_t    cfg,
    input  wire mpt_pkg::sample_t sample,
    input  wire logic            step,
    output mpt_pkg::result_t     result
);

    mpt_pkg::timer_state_t st_reg;
    mpt_pkg::timer_state_t st_next;

    mpt_pkg::time_ms_t el_base;
    mpt_pkg::time_ms_t off_t;

    // Elapsed time since the phase start, wrapping, and the blinker off time.
    assign el_base = sample.now_ms - st_reg.phase_start_ms;
    assign off_t   = (cfg.period_ms > cfg.duration_ms) ?
                     (cfg.period_ms - cfg.duration_ms) : '0;

    // Evaluate one sample against the current state.
    always_comb begin
        mpt_pkg::time_ms_t el;
        mpt_pkg::time_ms_t rem;
        mpt_pkg::time_ms_t prem;
        logic              run;
        logic              gate;

        st_next = st_reg;
        el      = el_base;
        rem     = '0;
        prem    = '0;
        run     = 1'b0;
        gate    = 1'b1;

        case (cfg.timer_mode)
            mpt_pkg::MODE_ON_DELAY: begin
                if (sample.trigger) begin
                    if (!st_reg.last_trigger) begin
                        st_next.phase_start_ms = sample.now_ms;
                        el = '0;
                    end
                    st_next.output_latch = (el >= cfg.duration_ms);
                    if (!st_next.output_latch) begin
                        rem = cfg.duration_ms - el;
                    end
                    prem = rem;
                    run  = 1'b1;
                end else begin
                    st_next.output_latch   = 1'b0;
                    st_next.phase_start_ms = sample.now_ms;
                end
            end

            mpt_pkg::MODE_OFF_DELAY: begin
                if (sample.trigger) begin
                    st_next.output_latch   = 1'b1;
                    st_next.phase_start_ms = sample.now_ms;
                    run = 1'b1;
                end else begin
                    if (st_reg.last_trigger) begin
                        st_next.phase_start_ms = sample.now_ms;
                        el = '0;
                    end
                    if (el >= cfg.duration_ms) begin
                        st_next.output_latch = 1'b0;
                    end else begin
                        st_next.output_latch = 1'b1;
                        rem  = cfg.duration_ms - el;
                        prem = rem;
                        run  = 1'b1;
                    end
                end
            end

            mpt_pkg::MODE_INTERVAL, mpt_pkg::MODE_INTERVAL_EN: begin
                // The gated form also needs the enable level.
                gate = (cfg.timer_mode == mpt_pkg::MODE_INTERVAL) || sample.enable;
                if (!gate || (cfg.period_ms == '0)) begin
                    st_next.output_latch  = 1'b0;
                    st_next.cycle_started = 1'b0;
                    st_next.in_on_phase   = 1'b0;
                end else begin
                    run = 1'b1;
                    if (!st_reg.cycle_started) begin
                        st_next.cycle_started  = 1'b1;
                        st_next.in_on_phase    = cfg.start_on_phase || (off_t == '0);
                        st_next.phase_start_ms = sample.now_ms;
                        el = '0;
                    end
                    if (st_next.in_on_phase) begin
                        st_next.output_latch = 1'b1;
                        if ((cfg.duration_ms == '0) || (off_t == '0)) begin
                            // Output holds on with no countdown.
                            rem = '0;
                        end else if (el >= cfg.duration_ms) begin
                            st_next.in_on_phase    = 1'b0;
                            st_next.phase_start_ms = sample.now_ms;
                            st_next.output_latch   = 1'b0;
                            prem = off_t;
                        end else begin
                            rem  = cfg.duration_ms - el;
                            prem = rem;
                        end
                    end else begin
                        st_next.output_latch = 1'b0;
                        if ((off_t == '0) || (el >= off_t)) begin
                            st_next.in_on_phase    = 1'b1;
                            st_next.phase_start_ms = sample.now_ms;
                            st_next.output_latch   = 1'b1;
                            rem  = cfg.duration_ms;
                            prem = cfg.duration_ms;
                        end else begin
                            prem = off_t - el;
                        end
                    end
                end
            end

            default: begin
                // Pulse: a rising trigger edge restarts the pulse.
                if (sample.trigger && !st_reg.last_trigger) begin
                    st_next.phase_start_ms = sample.now_ms;
                    st_next.output_latch   = 1'b1;
                    el = '0;
                end
                if (st_next.output_latch) begin
                    if (el >= cfg.duration_ms) begin
                        st_next.output_latch = 1'b0;
                    end else begin
                        rem  = cfg.duration_ms - el;
                        prem = rem;
                    end
                end
                run = st_next.output_latch;
            end
        endcase

        st_next.last_trigger = sample.trigger;

        // Assemble the result item.
        result.output_on          = st_next.output_latch;
        result.running            = run;
        result.remaining_ms       = rem;
        result.phase_remaining_ms = prem;
        if (!run) begin
            result.phase_code = mpt_pkg::PHASE_IDLE;
        end else if (st_next.output_latch) begin
            result.phase_code = mpt_pkg::PHASE_ON;
        end else begin
            result.phase_code = mpt_pkg::PHASE_OFF;
        end
    end

    // State advances only when an item passes through the evaluation.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (step) begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

/* design/multimode_plc_timer_top.sv */
// Top level of the multimode timer: input register, core evaluation, result register.
`default_nettype none

// One timer channel (pulse, on-delay, off-delay, blinker, gated blinker) that
// evaluates one sample item per clock. An accepted item sits in an input
// register, is evaluated against the channel state in one combinational pass,
// and lands in the result register, and a new item may be taken every cycle.
// The throughput of one item per cycle holds as long as results are taken; a
// stalled result register holds the input register, and ready falls once both
// are full. The channel state is updated as each item leaves the input
// register, so the next item always sees the state its predecessor left.
// Configuration writes take effect on the next cycle and belong in idle
// periods.
module multimode_plc_timer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    // Sample input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_trigger,
    input  wire logic        s_enable,
    input  wire logic [31:0] s_now_ms,
    // Result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_output_on,
    output logic             m_running,
    output logic [1:0]       m_phase_state,
    output logic [31:0]      m_remaining_ms,
    output logic [31:0]      m_phase_remaining_ms
);

    mpt_pkg::cfg_t    cfg;
    mpt_pkg::sample_t in_reg;
    mpt_pkg::result_t core_result;
    mpt_pkg::result_t out_reg;

    logic in_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic advance;
    logic in_load;

    mpt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mpt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .sample  (in_reg),
        .step    (advance),
        .result  (core_result)
    );

    // Handshake: an item moves forward when the stage ahead is free.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;
    assign in_load  = s_valid && s_ready;

    // Valid flags of the two stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_reg.trigger <= s_trigger;
            in_reg.enable  <= s_enable;
            in_reg.now_ms  <= s_now_ms;
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_output_on          = out_reg.output_on;
    assign m_running            = out_reg.running;
    assign m_phase_state        = out_reg.phase_code;
    assign m_remaining_ms       = out_reg.remaining_ms;
    assign m_phase_remaining_ms = out_reg.phase_remaining_ms;

endmodule

`default_nettype wire
